// File: sv/hvn_pkg.sv
// ----------------------------------------------------------------------------
// hvn_pkg
// Shared constants, types and register codes of the height field normal block.
// ----------------------------------------------------------------------------
package hvn_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int HEIGHT_BITS = 24;

  localparam int COL_AW   = $clog2(MAX_COLUMNS);
  localparam int COL_CW   = $clog2(MAX_COLUMNS + 1);
  localparam int STEP_W   = 24;
  localparam int ROWS_W   = 16;
  localparam int COLUMN_W = 11;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 24;
  localparam int NORM_W   = 16;

  localparam int DIFF_W  = HEIGHT_BITS + 1;
  localparam int MUL_A_W = (DIFF_W > STEP_W + 1) ? DIFF_W : STEP_W + 1;
  localparam int PROD_W  = MUL_A_W + STEP_W + 1;
  localparam int MAG_W   = PROD_W - 1;

  localparam int UNIT_BITS = 30;
  localparam int FRAC_BITS = 28;
  localparam int SQ_W      = 2 * UNIT_BITS + 2;
  localparam int ROOT_W    = 64;
  localparam int ROOT_TOP  = SQ_W;
  localparam int LEN_W     = UNIT_BITS + 1;
  localparam int NUM_W     = UNIT_BITS + FRAC_BITS + 1;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int QSTEP_W   = $clog2(QUO_W);
  localparam int REM_W     = LEN_W + 1;
  localparam int ACC_W     = 32;
  localparam int OUT_FRAC  = 14;
  localparam int XQ_W      = ACC_W - OUT_FRAC;

  localparam int              DIV3_IN_W  = 16;
  localparam logic [15:0]     DIV3_MUL   = 16'hAAAB;
  localparam int              DIV3_SHIFT = 17;

  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  localparam int NB_DOWN  = 0;
  localparam int NB_RIGHT = 1;
  localparam int NB_UP    = 2;
  localparam int NB_LEFT  = 3;

  typedef enum logic [CFG_IW-1:0] {
    REG_STEP_X       = 2'd0,
    REG_STEP_Y       = 2'd1,
    REG_ROW_COUNT    = 2'd2,
    REG_COLUMN_COUNT = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [STEP_W-1:0]   step_x;
    logic [STEP_W-1:0]   step_y;
    logic [ROWS_W-1:0]   row_count;
    logic [COLUMN_W-1:0] column_count;
  } cfg_regs_t;

  typedef struct packed {
    logic [HEIGHT_BITS-1:0]      centre;
    logic [3:0][HEIGHT_BITS-1:0] nb;
    logic [3:0]                  has;
    logic                        last;
  } job_t;

endpackage

// File: sv/hvn_sample_if.sv
// ----------------------------------------------------------------------------
// hvn_sample_if
// Input channel carrying height samples and drain ticks.
// ----------------------------------------------------------------------------
interface hvn_sample_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   action;
  logic signed [hvn_pkg::HEIGHT_BITS-1:0] height;

  modport source(output valid, action, height, input ready);
  modport sink(input valid, action, height, output ready);
endinterface

// File: sv/hvn_normal_if.sv
// ----------------------------------------------------------------------------
// hvn_normal_if
// Output channel carrying one vertex normal per word.
// ----------------------------------------------------------------------------
interface hvn_normal_if;
  logic                              valid;
  logic                              ready;
  logic signed [hvn_pkg::NORM_W-1:0] normal_x;
  logic signed [hvn_pkg::NORM_W-1:0] normal_y;
  logic signed [hvn_pkg::NORM_W-1:0] normal_z;
  logic                              degenerate;
  logic                              frame_end;

  modport source(output valid, normal_x, normal_y, normal_z, degenerate, frame_end,
                 input ready);
  modport sink(input valid, normal_x, normal_y, normal_z, degenerate, frame_end,
               output ready);
endinterface

// File: sv/hvn_cfg_if.sv
// ----------------------------------------------------------------------------
// hvn_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface hvn_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [hvn_pkg::CFG_IW-1:0]  index;
  logic [hvn_pkg::CFG_DW-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: sv/heightfield_vertex_normals.sv
// ----------------------------------------------------------------------------
// heightfield_vertex_normals
// Vertex normals of a streamed height field, emitted one grid row behind.
// ----------------------------------------------------------------------------
// Channel   Role   Word
// samples   sink   action, height (drain tick or height sample)
// normals   source normal_x, normal_y, normal_z, degenerate, frame_end
// cfg       sink   index, data (register write, always ready)
//
// The front takes a word only while idle and the job queue has room; each
// word then needs three reads of the row stores, which have one read port
// each. The back forms the products of a point and, per kept triangle, runs
// a normalizing shift, a 32-step square root and three 29-step divisions.
// Reset is synchronous; the row stores are not cleared.
// A two-entry job queue lets the front run ahead while the back or the
// output side stalls.
// ----------------------------------------------------------------------------
module heightfield_vertex_normals (
  input  logic       clk,
  input  logic       rst,
  hvn_sample_if.sink samples,
  hvn_normal_if.source normals,
  hvn_cfg_if.sink    cfg
);
  import hvn_pkg::*;

  cfg_regs_t regs;
  logic      cfg_write;
  logic      restart;
  logic      push;
  job_t      push_job;
  logic      q_full;
  logic      pop;
  job_t      pop_job;
  logic      q_empty;

  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid && cfg.ready;
  assign restart   = cfg_write && ((reg_index_t'(cfg.index) == REG_ROW_COUNT) ||
                                   (reg_index_t'(cfg.index) == REG_COLUMN_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.step_x       <= STEP_W'(65536);
      regs.step_y       <= STEP_W'(65536);
      regs.row_count    <= ROWS_W'(64);
      regs.column_count <= COLUMN_W'(64);
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg.index))
        REG_STEP_X:       regs.step_x       <= cfg.data[STEP_W-1:0];
        REG_STEP_Y:       regs.step_y       <= cfg.data[STEP_W-1:0];
        REG_ROW_COUNT:    regs.row_count    <= cfg.data[ROWS_W-1:0];
        REG_COLUMN_COUNT: regs.column_count <= cfg.data[COLUMN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  hvn_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (regs),
    .restart  (restart),
    .samples  (samples),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  hvn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  hvn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (regs),
    .job_valid (!q_empty),
    .job       (pop_job),
    .job_take  (pop),
    .normals   (normals)
  );

endmodule

// File: sv/hvn_ram.sv
// ----------------------------------------------------------------------------
// hvn_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: sv/hvn_front.sv
// ----------------------------------------------------------------------------
// hvn_front
// Tracks the grid position, classifies each word, gathers the centre, up, left
// and right heights from the two row stores and queues one job per normal.
// ----------------------------------------------------------------------------
module hvn_front (
  input  logic               clk,
  input  logic               rst,
  input  hvn_pkg::cfg_regs_t cfg,
  input  logic               restart,
  hvn_sample_if.sink         samples,
  input  logic               q_full,
  output logic               push,
  output hvn_pkg::job_t      push_job
);
  import hvn_pkg::*;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_RD0  = 5'b00010,
    F_RD1  = 5'b00100,
    F_RD2  = 5'b01000,
    F_WR   = 5'b10000
  } front_state_t;

  front_state_t state;

  logic [ROWS_W-1:0] row_pos;
  logic [COL_AW-1:0] col_pos;
  logic [COL_AW-1:0] drain_pos;

  logic [ROWS_W-1:0] rows_eff;
  logic [COL_CW-1:0] cols_eff;
  logic [COL_CW-1:0] pos_w;
  logic [COL_CW-1:0] c_full;
  logic [COL_AW-1:0] c_sel;
  logic [COL_CW-1:0] c_plus;
  logic              c_inner;
  logic              draining;
  logic              accept;
  logic              take;

  logic [COL_AW-1:0]      c_idx;
  logic                   is_drain;
  logic                   produce;
  logic [HEIGHT_BITS-1:0] h_r;
  logic [HEIGHT_BITS-1:0] centre_r;
  logic [HEIGHT_BITS-1:0] right_r;
  logic [HEIGHT_BITS-1:0] up_r;
  logic [HEIGHT_BITS-1:0] left_r;
  logic [3:0]             has_r;
  logic                   last_r;

  logic [COL_AW-1:0]      newer_rd_addr;
  logic [COL_AW-1:0]      older_rd_addr;
  logic [HEIGHT_BITS-1:0] newer_q;
  logic [HEIGHT_BITS-1:0] older_q;
  logic                   newer_wr;
  logic                   older_wr;

  always_comb begin
    rows_eff = (cfg.row_count == '0) ? ROWS_W'(1) : cfg.row_count;
    if (cfg.column_count == '0) begin
      cols_eff = COL_CW'(1);
    end else if (int'(cfg.column_count) > MAX_COLUMNS) begin
      cols_eff = COL_CW'(MAX_COLUMNS);
    end else begin
      cols_eff = COL_CW'(cfg.column_count);
    end
    pos_w    = samples.action ? COL_CW'(drain_pos) : COL_CW'(col_pos);
    c_full   = (pos_w < cols_eff) ? pos_w : cols_eff - COL_CW'(1);
    c_sel    = c_full[COL_AW-1:0];
    c_plus   = c_full + COL_CW'(1);
    c_inner  = c_plus < cols_eff;
    draining = row_pos >= rows_eff;
  end

  assign samples.ready = (state == F_IDLE) && !q_full;
  assign accept        = samples.valid && samples.ready;
  assign take          = accept && (samples.action ? draining : !draining);

  always_comb begin
    newer_rd_addr = c_idx;
    older_rd_addr = c_idx;
    unique case (state)
      F_RD1: begin
        newer_rd_addr = c_idx + COL_AW'(1);
        older_rd_addr = c_idx - COL_AW'(1);
      end
      F_RD2: begin
        newer_rd_addr = c_idx - COL_AW'(1);
      end
      default: begin
      end
    endcase
  end

  assign newer_wr = (state == F_WR) && !is_drain;
  assign older_wr = (state == F_WR) && !is_drain && produce;
  assign push     = (state == F_WR) && produce;

  always_comb begin
    push_job                = '0;
    push_job.centre         = centre_r;
    push_job.nb[NB_DOWN]    = h_r;
    push_job.nb[NB_RIGHT]   = right_r;
    push_job.nb[NB_UP]      = up_r;
    push_job.nb[NB_LEFT]    = is_drain ? newer_q : left_r;
    push_job.has            = has_r;
    push_job.last           = last_r;
  end

  hvn_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(MAX_COLUMNS)) u_newer (
    .clk     (clk),
    .wr_en   (newer_wr),
    .wr_addr (c_idx),
    .wr_data (h_r),
    .rd_addr (newer_rd_addr),
    .rd_data (newer_q)
  );

  hvn_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(MAX_COLUMNS)) u_older (
    .clk     (clk),
    .wr_en   (older_wr),
    .wr_addr (c_idx),
    .wr_data (centre_r),
    .rd_addr (older_rd_addr),
    .rd_data (older_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      row_pos   <= '0;
      col_pos   <= '0;
      drain_pos <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (take) begin
            c_idx       <= c_sel;
            is_drain    <= samples.action;
            produce     <= samples.action || (row_pos != '0);
            h_r         <= samples.height;
            has_r[NB_DOWN]  <= !samples.action;
            has_r[NB_RIGHT] <= c_inner;
            has_r[NB_UP]    <= samples.action ? (rows_eff >= ROWS_W'(2))
                                              : (row_pos >= ROWS_W'(2));
            has_r[NB_LEFT]  <= c_sel != '0;
            last_r      <= samples.action && !c_inner;
            if (samples.action) begin
              if (!c_inner) begin
                row_pos   <= '0;
                col_pos   <= '0;
                drain_pos <= '0;
              end else begin
                drain_pos <= c_plus[COL_AW-1:0];
              end
            end else begin
              if (!c_inner) begin
                col_pos   <= '0;
                row_pos   <= row_pos + ROWS_W'(1);
                drain_pos <= '0;
              end else begin
                col_pos <= c_plus[COL_AW-1:0];
              end
            end
            state <= F_RD0;
          end
        end
        F_RD0: begin
          state <= F_RD1;
        end
        F_RD1: begin
          centre_r <= newer_q;
          up_r     <= older_q;
          state    <= F_RD2;
        end
        F_RD2: begin
          right_r <= newer_q;
          left_r  <= older_q;
          state   <= F_WR;
        end
        F_WR: begin
          state <= F_IDLE;
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
      if (restart) begin
        row_pos   <= '0;
        col_pos   <= '0;
        drain_pos <= '0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("Job pushed into a full queue.");
`endif

endmodule

// File: sv/hvn_queue.sv
// ----------------------------------------------------------------------------
// hvn_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module hvn_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hvn_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output hvn_pkg::job_t pop_job,
  output logic          empty
);
  import hvn_pkg::*;

  job_t            slots [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr;
  logic [QP_W-1:0] rd_ptr;
  logic [QC_W-1:0] fill;

  assign full    = fill == QC_W'(QUEUE_DEPTH);
  assign empty   = fill == '0;
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QP_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QP_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QC_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QC_W'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("Job taken from an empty queue.");
`endif

endmodule

// File: sv/hvn_back.sv
// ----------------------------------------------------------------------------
// hvn_back
// Forms the triangle normals of one job, scales each to unit length with an
// iterative square root and divider, averages them and holds the result word.
// ----------------------------------------------------------------------------
module hvn_back (
  input  logic               clk,
  input  logic               rst,
  input  hvn_pkg::cfg_regs_t cfg,
  input  logic               job_valid,
  input  hvn_pkg::job_t      job,
  output logic               job_take,
  hvn_normal_if.source       normals
);
  import hvn_pkg::*;

  typedef enum logic [9:0] {
    B_IDLE  = 10'b0000000001,
    B_MUL   = 10'b0000000010,
    B_TRI   = 10'b0000000100,
    B_NORM  = 10'b0000001000,
    B_SQ    = 10'b0000010000,
    B_ROOT  = 10'b0000100000,
    B_DLOAD = 10'b0001000000,
    B_DIV   = 10'b0010000000,
    B_FIN   = 10'b0100000000,
    B_OUT   = 10'b1000000000
  } back_state_t;

  back_state_t state;
  job_t        job_r;

  logic [2:0]               mul_idx;
  logic signed [PROD_W-1:0] prod_r [5];
  logic [1:0]               tri_idx;
  logic [MAG_W-1:0]         mag [3];
  logic [2:0]               neg;
  logic [1:0]               comp;
  logic [SQ_W-1:0]          sq_sum;
  logic [ROOT_W-1:0]        rad;
  logic [ROOT_W-1:0]        root;
  logic [ROOT_W-1:0]        rbit;
  logic [LEN_W-1:0]         len;
  logic [REM_W-1:0]         rem;
  logic [QUO_W-1:0]         num_lo;
  logic [QUO_W-1:0]         quo;
  logic [QSTEP_W-1:0]       qstep;
  logic signed [ACC_W-1:0]  acc [3];
  logic [2:0]               count;
  logic [NORM_W-1:0]        res [3];
  logic                     out_valid;

  logic signed [DIFF_W-1:0]   diff;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [STEP_W:0]     mul_b;
  logic signed [PROD_W-1:0]   prod;

  logic                     keep;
  logic signed [PROD_W-1:0] tx;
  logic signed [PROD_W-1:0] ty;
  logic [PROD_W-1:0]        ax;
  logic [PROD_W-1:0]        ay;

  logic [MAG_W-1:0] mag_or;
  logic             too_wide;

  logic [ROOT_W-1:0] trial;
  logic              root_ge;
  logic [ROOT_W-1:0] root_n;
  logic [ROOT_W-1:0] rad_n;

  logic [NUM_W-1:0] num;
  logic [REM_W-1:0] rem_sh;
  logic             div_ge;
  logic [QUO_W-1:0] quo_n;
  logic [ACC_W-1:0] unit_ext;

  logic signed [ACC_W-1:0] fin_a;
  logic [ACC_W-1:0]        fin_m;
  logic [ACC_W-1:0]        fin_sum;
  logic [XQ_W-1:0]         xq;
  logic [2*DIV3_IN_W-1:0]  recip_p;
  logic [XQ_W-1:0]         qm;
  logic [NORM_W-1:0]       fin_res;

  assign job_take = (state == B_IDLE) && job_valid;

  always_comb begin
    diff  = $signed({job_r.nb[mul_idx[1:0]][HEIGHT_BITS-1], job_r.nb[mul_idx[1:0]]})
          - $signed({job_r.centre[HEIGHT_BITS-1], job_r.centre});
    mul_a = MUL_A_W'(diff);
    mul_b = $signed({1'b0, cfg.step_y});
    unique case (mul_idx)
      3'd1, 3'd3: begin
        mul_b = $signed({1'b0, cfg.step_x});
      end
      3'd4: begin
        mul_a = MUL_A_W'($signed({1'b0, cfg.step_x}));
      end
      default: begin
      end
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    keep = 1'b0;
    tx   = '0;
    ty   = '0;
    unique case (tri_idx)
      2'd0: begin
        keep = job_r.has[NB_DOWN] && job_r.has[NB_RIGHT];
        tx   = -prod_r[0];
        ty   = -prod_r[1];
      end
      2'd1: begin
        keep = job_r.has[NB_LEFT] && job_r.has[NB_DOWN];
        tx   = -prod_r[0];
        ty   = prod_r[3];
      end
      2'd2: begin
        keep = job_r.has[NB_UP] && job_r.has[NB_LEFT];
        tx   = prod_r[2];
        ty   = prod_r[3];
      end
      2'd3: begin
        keep = job_r.has[NB_RIGHT] && job_r.has[NB_UP];
        tx   = prod_r[2];
        ty   = -prod_r[1];
      end
      default: begin
      end
    endcase
    ax = tx[PROD_W-1] ? -tx : tx;
    ay = ty[PROD_W-1] ? -ty : ty;
  end

  assign mag_or   = mag[0] | mag[1] | mag[2];
  assign too_wide = (mag_or >> UNIT_BITS) != '0;

  always_comb begin
    trial   = root + rbit;
    root_ge = rad >= trial;
    root_n  = root_ge ? (root >> 1) + rbit : root >> 1;
    rad_n   = root_ge ? rad - trial : rad;
  end

  always_comb begin
    num      = {mag[comp][UNIT_BITS-1:0], FRAC_BITS'(0)} + NUM_W'(len >> 1);
    rem_sh   = {rem[REM_W-2:0], num_lo[QUO_W-1]};
    div_ge   = rem_sh >= REM_W'(len);
    quo_n    = {quo[QUO_W-2:0], div_ge};
    unit_ext = ACC_W'(quo_n);
  end

  always_comb begin
    fin_a   = acc[comp];
    fin_m   = fin_a[ACC_W-1] ? ACC_W'(-fin_a) : ACC_W'(fin_a);
    fin_sum = fin_m + (ACC_W'(count) << (OUT_FRAC - 1));
    xq      = fin_sum[ACC_W-1:OUT_FRAC];
    recip_p = xq[DIV3_IN_W-1:0] * DIV3_MUL;
    unique case (count)
      3'd1:    qm = xq;
      3'd2:    qm = xq >> 1;
      3'd3:    qm = XQ_W'(recip_p >> DIV3_SHIFT);
      3'd4:    qm = xq >> 2;
      default: qm = '0;
    endcase
    fin_res = fin_a[ACC_W-1] ? -NORM_W'(qm) : NORM_W'(qm);
  end

  assign normals.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && normals.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (job_valid) begin
            job_r   <= job;
            mul_idx <= '0;
            count   <= '0;
            for (int k = 0; k < 3; k++) begin
              acc[k] <= '0;
            end
            state <= B_MUL;
          end
        end
        B_MUL: begin
          prod_r[mul_idx] <= prod;
          mul_idx         <= mul_idx + 3'd1;
          if (mul_idx == 3'd4) begin
            tri_idx <= '0;
            state   <= B_TRI;
          end
        end
        B_TRI: begin
          if (!keep || (tx == '0 && ty == '0 && prod_r[4] == '0)) begin
            if (tri_idx == 2'd3) begin
              comp  <= '0;
              state <= B_FIN;
            end else begin
              tri_idx <= tri_idx + 2'd1;
            end
          end else begin
            mag[0] <= ax[MAG_W-1:0];
            mag[1] <= ay[MAG_W-1:0];
            mag[2] <= prod_r[4][MAG_W-1:0];
            neg    <= {1'b0, ty[PROD_W-1], tx[PROD_W-1]};
            state  <= B_NORM;
          end
        end
        B_NORM: begin
          if (too_wide) begin
            for (int k = 0; k < 3; k++) begin
              mag[k] <= mag[k] >> 1;
            end
          end else if (!mag_or[UNIT_BITS-1]) begin
            for (int k = 0; k < 3; k++) begin
              mag[k] <= mag[k] << 1;
            end
          end else begin
            comp   <= '0;
            sq_sum <= '0;
            state  <= B_SQ;
          end
        end
        B_SQ: begin
          if (comp == 2'd2) begin
            rad   <= ROOT_W'(sq_sum + SQ_W'(mag[2][UNIT_BITS-1:0] * mag[2][UNIT_BITS-1:0]));
            root  <= '0;
            rbit  <= ROOT_W'(1) << ROOT_TOP;
            state <= B_ROOT;
          end else begin
            sq_sum <= sq_sum + SQ_W'(mag[comp][UNIT_BITS-1:0] * mag[comp][UNIT_BITS-1:0]);
            comp   <= comp + 2'd1;
          end
        end
        B_ROOT: begin
          rad  <= rad_n;
          root <= root_n;
          rbit <= rbit >> 2;
          if (rbit == ROOT_W'(1)) begin
            len   <= root_n[LEN_W-1:0];
            comp  <= '0;
            state <= B_DLOAD;
          end
        end
        B_DLOAD: begin
          rem    <= REM_W'(num[NUM_W-1:QUO_W]);
          num_lo <= num[QUO_W-1:0];
          quo    <= '0;
          qstep  <= '0;
          state  <= B_DIV;
        end
        B_DIV: begin
          rem    <= div_ge ? rem_sh - REM_W'(len) : rem_sh;
          num_lo <= num_lo << 1;
          quo    <= quo_n;
          qstep  <= qstep + QSTEP_W'(1);
          if (qstep == QSTEP_W'(QUO_W - 1)) begin
            acc[comp] <= neg[comp] ? acc[comp] - $signed(unit_ext)
                                   : acc[comp] + $signed(unit_ext);
            if (comp == 2'd2) begin
              count <= count + 3'd1;
              if (tri_idx == 2'd3) begin
                comp  <= '0;
                state <= B_FIN;
              end else begin
                tri_idx <= tri_idx + 2'd1;
                state   <= B_TRI;
              end
            end else begin
              comp  <= comp + 2'd1;
              state <= B_DLOAD;
            end
          end
        end
        B_FIN: begin
          res[comp] <= fin_res;
          if (comp == 2'd2) begin
            state <= B_OUT;
          end else begin
            comp <= comp + 2'd1;
          end
        end
        B_OUT: begin
          if (!out_valid || normals.ready) begin
            normals.normal_x   <= res[0];
            normals.normal_y   <= res[1];
            normals.normal_z   <= res[2];
            normals.degenerate <= count == '0;
            normals.frame_end  <= job_r.last;
            out_valid          <= 1'b1;
            state              <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_norm_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == B_NORM) |-> (mag_or != '0))
    else $error("Normalizing an all-zero triangle vector.");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("More than four triangles counted.");

  a_rem_below_len: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV) |-> (rem < REM_W'(len)))
    else $error("Divider remainder not below the length.");

  a_out_loads_free: assert property (@(posedge clk) disable iff (rst)
    (state == B_OUT && out_valid && !normals.ready) |=> (state == B_OUT))
    else $error("Result word overwritten while still held.");
`endif

endmodule
